// ===== rtl/yrgb_pkg.sv =====
// shared types and constants for the bt.601 yuv to bgr pixel converter
// used by yrgb_lane and yuv_to_rgb_pixel_converter; no dependencies

package yrgb_pkg;

    // fixed-point coefficients, 16 fractional bits, truncated
    localparam int COEF_W = 19;
    localparam logic signed [COEF_W-1:0] COEF_Y  = 19'sd76283;
    localparam logic signed [COEF_W-1:0] COEF_UG = 19'sd25690;
    localparam logic signed [COEF_W-1:0] COEF_UB = 19'sd132186;
    localparam logic signed [COEF_W-1:0] COEF_VR = 19'sd104595;
    localparam logic signed [COEF_W-1:0] COEF_VG = 19'sd53280;

    localparam logic signed [8:0] LUMA_OFFSET   = 9'sd16;
    localparam logic signed [8:0] CHROMA_OFFSET = 9'sd128;

    // offset component (9) times coefficient (19)
    localparam int PROD_W = 28;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = 28'sd32768;
    localparam int FRAC_BITS = 16;

    // source_format codes
    localparam logic FMT_YUV422 = 1'b0;
    localparam logic FMT_RGB32  = 1'b1;

    typedef logic signed [PROD_W-1:0] prod_t;

    // chroma products shared by both luma lanes
    typedef struct packed {
        prod_t ub;
        prod_t ug;
        prod_t vg;
        prod_t vr;
    } chroma_t;

    // blue in the lowest byte, then green, then red
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

endpackage

// ===== rtl/yrgb_lane.sv =====
// one luma lane: luma product, bgr sums and clamp over three register stages
// depends on yrgb_pkg

module yrgb_lane (
    input  logic             aclk,
    input  logic             en,          // pipeline advance
    input  logic [7:0]       luma,        // stage 1 luma byte
    input  yrgb_pkg::chroma_t chroma,     // stage 2 chroma products
    output yrgb_pkg::pixel_t pixel        // stage 4 clamped pixel
);

    logic signed [8:0]    luma_off;
    yrgb_pkg::prod_t      luma_prod_next;
    yrgb_pkg::prod_t      luma_prod_reg;
    yrgb_pkg::prod_t      sum_b_next, sum_g_next, sum_r_next;
    yrgb_pkg::prod_t      sum_b_reg, sum_g_reg, sum_r_reg;
    yrgb_pkg::pixel_t     pixel_next;
    yrgb_pkg::pixel_t     pixel_reg;

    // sum already carries the rounding half; floor shift then clamp to 0..255
    function automatic logic [7:0] clamp_comp(input yrgb_pkg::prod_t s);
        logic [7:0] res;
        if (s[yrgb_pkg::PROD_W-1]) begin
            res = 8'd0;
        end else if (|s[yrgb_pkg::PROD_W-2:yrgb_pkg::FRAC_BITS+8]) begin
            res = 8'hff;
        end else begin
            res = s[yrgb_pkg::FRAC_BITS+7:yrgb_pkg::FRAC_BITS];
        end
        return res;
    endfunction

    always_comb begin
        luma_off       = $signed({1'b0, luma}) - yrgb_pkg::LUMA_OFFSET;
        luma_prod_next = yrgb_pkg::prod_t'(luma_off) * yrgb_pkg::prod_t'(yrgb_pkg::COEF_Y);
        sum_b_next = luma_prod_reg + chroma.ub + yrgb_pkg::ROUND_HALF;
        sum_g_next = luma_prod_reg - chroma.ug - chroma.vg + yrgb_pkg::ROUND_HALF;
        sum_r_next = luma_prod_reg + chroma.vr + yrgb_pkg::ROUND_HALF;
        pixel_next.blue  = clamp_comp(sum_b_reg);
        pixel_next.green = clamp_comp(sum_g_reg);
        pixel_next.red   = clamp_comp(sum_r_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            luma_prod_reg <= luma_prod_next;
            sum_b_reg     <= sum_b_next;
            sum_g_reg     <= sum_g_next;
            sum_r_reg     <= sum_r_next;
            pixel_reg     <= pixel_next;
        end
    end

    assign pixel = pixel_reg;

endmodule

// ===== rtl/yuv_to_rgb_pixel_converter.sv =====
// an input passes capture, product, sum and clamp registers before its first output pixel
// throughput: one input transaction per cycle in bgra mode or with first_only set;
//   a full 4:2:2 pair gives two pixels, one per cycle on the output port
// a stall at the output holds the whole pipeline; nothing is lost or repeated
// reset (aresetn low, synchronous) empties the pipeline and selects yuv 4:2:2
// depends on yrgb_pkg and yrgb_lane

module yuv_to_rgb_pixel_converter (
    input  logic        aclk,
    input  logic        aresetn,

    // configuration: source_format
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,

    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // byte0 [7:0], byte1 [15:8], byte2 [23:16], byte3 [31:24]
    input  logic        s_tuser,   // first_only
    input  logic        s_tlast,   // row_end

    // output stream, one pixel per transaction
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // blue [7:0], green [15:8], red [23:16]
    output logic        m_tuser,   // last_of_item
    output logic        m_tlast    // end_of_row
);

    // ---------------------------------------------------------------
    // configuration register
    // ---------------------------------------------------------------
    logic fmt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg <= yrgb_pkg::FMT_YUV422;
        end else if (cfg_wr_en) begin
            fmt_reg <= cfg_wr_data;
        end
    end

    // ---------------------------------------------------------------
    // pipeline control: every stage moves together on adv
    // ---------------------------------------------------------------
    logic adv;
    logic out_fire;
    logic out_final;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;

    // per-stage side info: format, flags and raw bytes for the bgra bypass
    logic        s1_fmt_reg, s2_fmt_reg, s3_fmt_reg, s4_fmt_reg;
    logic        s1_first_reg, s2_first_reg, s3_first_reg, s4_first_reg;
    logic        s1_row_end_reg, s2_row_end_reg, s3_row_end_reg, s4_row_end_reg;
    logic [31:0] s1_data_reg;
    yrgb_pkg::pixel_t s2_raw_reg, s3_raw_reg, s4_raw_reg;

    // which pixel of a pair is on the output
    logic sel_reg;
    logic sel_next;

    // the pipeline can shift when the output stage is empty or finishes this cycle
    assign adv      = !s4_valid_reg || (m_tready && out_final);
    assign s_tready = adv;
    assign out_fire = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= s_tvalid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            // stage 1: capture the transaction
            s1_fmt_reg     <= fmt_reg;
            s1_first_reg   <= s_tuser;
            s1_row_end_reg <= s_tlast;
            s1_data_reg    <= s_tdata;
            // stage 2
            s2_fmt_reg     <= s1_fmt_reg;
            s2_first_reg   <= s1_first_reg;
            s2_row_end_reg <= s1_row_end_reg;
            s2_raw_reg     <= s1_data_reg[23:0];
            // stage 3
            s3_fmt_reg     <= s2_fmt_reg;
            s3_first_reg   <= s2_first_reg;
            s3_row_end_reg <= s2_row_end_reg;
            s3_raw_reg     <= s2_raw_reg;
            // stage 4: output stage
            s4_fmt_reg     <= s3_fmt_reg;
            s4_first_reg   <= s3_first_reg;
            s4_row_end_reg <= s3_row_end_reg;
            s4_raw_reg     <= s3_raw_reg;
        end
    end

    // ---------------------------------------------------------------
    // stage 2: chroma products, shared by both lanes
    // ---------------------------------------------------------------
    logic signed [8:0]  u_off, v_off;
    yrgb_pkg::chroma_t  chroma_next;
    yrgb_pkg::chroma_t  chroma_reg;

    always_comb begin
        u_off = $signed({1'b0, s1_data_reg[15:8]})  - yrgb_pkg::CHROMA_OFFSET;
        v_off = $signed({1'b0, s1_data_reg[31:24]}) - yrgb_pkg::CHROMA_OFFSET;
        chroma_next.ub = yrgb_pkg::prod_t'(u_off) * yrgb_pkg::prod_t'(yrgb_pkg::COEF_UB);
        chroma_next.ug = yrgb_pkg::prod_t'(u_off) * yrgb_pkg::prod_t'(yrgb_pkg::COEF_UG);
        chroma_next.vg = yrgb_pkg::prod_t'(v_off) * yrgb_pkg::prod_t'(yrgb_pkg::COEF_VG);
        chroma_next.vr = yrgb_pkg::prod_t'(v_off) * yrgb_pkg::prod_t'(yrgb_pkg::COEF_VR);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            chroma_reg <= chroma_next;
        end
    end

    // ---------------------------------------------------------------
    // stages 2..4: two luma lanes, y0 and y1
    // ---------------------------------------------------------------
    yrgb_pkg::pixel_t pix0, pix1;

    yrgb_lane u_lane0 (
        .aclk   (aclk),
        .en     (adv),
        .luma   (s1_data_reg[7:0]),
        .chroma (chroma_reg),
        .pixel  (pix0)
    );

    yrgb_lane u_lane1 (
        .aclk   (aclk),
        .en     (adv),
        .luma   (s1_data_reg[23:16]),
        .chroma (chroma_reg),
        .pixel  (pix1)
    );

    // ---------------------------------------------------------------
    // output stage: one pixel per transaction
    // ---------------------------------------------------------------
    // bgra and odd row tails give a single pixel, otherwise the second one ends the item
    assign out_final = (s4_fmt_reg == yrgb_pkg::FMT_RGB32) || s4_first_reg || sel_reg;

    always_comb begin
        sel_next = sel_reg;
        if (out_fire) begin
            sel_next = !out_final;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg <= 1'b0;
        end else begin
            sel_reg <= sel_next;
        end
    end

    always_comb begin
        if (s4_fmt_reg == yrgb_pkg::FMT_RGB32) begin
            m_tdata = s4_raw_reg;
        end else if (sel_reg) begin
            m_tdata = pix1;
        end else begin
            m_tdata = pix0;
        end
    end

    assign m_tvalid = s4_valid_reg;
    assign m_tuser  = out_final;
    assign m_tlast  = out_final && s4_row_end_reg;

endmodule
